/* sv/assert_macros.svh */
// Assertion helpers used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* sv/lfpa_pkg.sv */
`timescale 1ns / 1ps

package lfpa_pkg;

  localparam int ACTIVE_W      = 7;
  localparam int PROC_W        = 7;
  localparam int TIME_W        = 32;
  localparam int FIN_W         = TIME_W + 1;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 2;
  localparam int MAX_PROCS_DEF = 64;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);

  typedef struct packed {
    logic [TIME_W-1:0] task_start;
    logic [TIME_W-1:0] duration;
  } in_t;

  typedef struct packed {
    logic [PROC_W-1:0] proc_number;
    logic              none_free;
  } out_t;

  typedef struct packed {
    logic              release_en;
    logic              assign_en;
    logic [TIME_W-1:0] task_start;
    logic [FIN_W-1:0]  finish;
  } cell_ctl_t;

endpackage

/* sv/lfpa_cell.sv */
`timescale 1ns / 1ps

module lfpa_cell (
  input  logic               clk,
  input  logic               rst,
  input  lfpa_pkg::cell_ctl_t ctl,
  input  logic               active,
  input  logic               search_in,
  output logic               search_out,
  output logic               grant
);
  import lfpa_pkg::*;

  logic             busy;
  logic [FIN_W-1:0] finish;
  logic             take;

  assign take       = search_in & active & ~busy;
  assign grant      = take;
  assign search_out = search_in & ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.release_en) begin
      if (busy && (finish <= {1'b0, ctl.task_start})) begin
        busy <= 1'b0;
      end
    end else if (ctl.assign_en && take) begin
      busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.assign_en && take) begin
      finish <= ctl.finish;
    end
  end

endmodule

/* sv/lfpa_cfg.sv */
`timescale 1ns / 1ps

module lfpa_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfpa_pkg::DATA_W-1:0]   pwdata,
  output logic [lfpa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [lfpa_pkg::ACTIVE_W-1:0] active_procs
);
  import lfpa_pkg::*;

  logic wr_en;

  // one register; every word address decodes to it
  assign wr_en  = psel & penable & pwrite & pready & (paddr == paddr);
  assign pready = 1'b1;
  assign prdata = DATA_W'(active_procs);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_procs <= ACTIVE_RESET;
    end else if (wr_en) begin
      active_procs <= pwdata[ACTIVE_W-1:0];
    end
  end

endmodule

/* sv/lowest_free_processor_allocator_core.sv */
// Lowest-index free processor allocator. Each transaction on the input
// channel carries a task start time and duration; the block releases every
// busy processor whose finish time is at or before the start time, then
// claims the lowest-numbered free processor among the first active_procs and
// returns its 1-based number, or none_free with number 0 when all are busy.
// The release compare runs in every cell at the input transaction edge, and
// the claim ripples through the row of cells in the S_ASSIGN state after it,
// one cell per processor, held while an output result stalls. The result sits
// in an output register, so a new task is taken while the previous result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lowest_free_processor_allocator_core #(
  parameter int MAX_PROCS = lfpa_pkg::MAX_PROCS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lfpa_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lfpa_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfpa_pkg::DATA_W-1:0]   pwdata,
  output logic [lfpa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lfpa_pkg::*;

  localparam int NUM_W = $clog2(MAX_PROCS + 1);
  localparam int CNT_W = (NUM_W > ACTIVE_W) ? NUM_W : ACTIVE_W;

  typedef enum logic {S_IDLE, S_ASSIGN} state_t;

  state_t              state;
  logic [FIN_W-1:0]    finish;
  logic [ACTIVE_W-1:0] active_procs;
  logic                in_accept;
  logic                assign_en;
  cell_ctl_t           ctl;
  logic [MAX_PROCS-1:0] active;
  logic [MAX_PROCS-1:0] grant;
  logic [MAX_PROCS:0]   search;
  logic [NUM_W-1:0]     sel_num;

  lfpa_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .active_procs (active_procs)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign assign_en = (state == S_ASSIGN) & (~out_valid | ~out_stall);

  always_comb begin
    ctl.release_en = in_accept;
    ctl.assign_en  = assign_en;
    ctl.task_start = in_data.task_start;
    ctl.finish     = finish;
  end

  assign search[0] = 1'b1;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    assign active[i] = CNT_W'(i) < CNT_W'(active_procs);

    lfpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .active     (active[i]),
      .search_in  (search[i]),
      .search_out (search[i+1]),
      .grant      (grant[i])
    );
  end

  always_comb begin
    sel_num = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (grant[i]) begin
        sel_num = sel_num | NUM_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (in_accept) begin
            state <= S_ASSIGN;
          end
        end
        S_ASSIGN: begin
          if (assign_en) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      finish <= FIN_W'(in_data.task_start) + FIN_W'(in_data.duration);
    end
    if (assign_en) begin
      out_data.proc_number <= PROC_W'(sel_num);
      out_data.none_free   <= search[MAX_PROCS];
    end
  end

  `ASSERT_CLK(a_grant_onehot, $onehot0(grant), "more than one processor claimed")
  `ASSERT_IMPLIES(a_flag_matches_number, out_valid,
    out_data.none_free == (out_data.proc_number == '0), "none_free disagrees with number")
  `ASSERT_NEXT(a_two_cycle_item, in_accept, !in_accept && (state == S_ASSIGN),
    "task accepted while previous one is still assigning")
  `ASSERT_IMPLIES(a_grant_only_active, |grant, |(grant & active),
    "inactive processor claimed")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lfpa_pkg::*;

  localparam int NPROC = MAX_PROCS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ADDR_W-1:0] ACTIVE_PROCS_ADDR = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [ACTIVE_W-1:0] model_active = ACTIVE_RESET;
  logic busy_model [NPROC];
  logic [FIN_W-1:0] finish_model [NPROC];
  in_t pending_jobs [$];
  out_t expected_assignments [$];
  out_t due_assignment;
  int mismatch_count = 0;
  int in_gap_pct = 30;
  int out_stall_pct = 30;
  int cycle_count = 0;
  logic [TIME_W-1:0] now_time = '0;

  lowest_free_processor_allocator_core dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic out_t assign_processor(in_t job);
    out_t res;
    logic [FIN_W-1:0] fin;
    int lim;
    res.proc_number = '0;
    res.none_free = 1'b1;
    fin = {1'b0, job.task_start} + {1'b0, job.duration};
    lim = (model_active > NPROC) ? NPROC : int'(model_active);
    for (int i = 0; i < NPROC; i++) begin
      if (busy_model[i] && finish_model[i] <= {1'b0, job.task_start}) busy_model[i] = 1'b0;
    end
    for (int i = 0; i < lim; i++) begin
      if (!busy_model[i] && res.none_free) begin
        busy_model[i] = 1'b1;
        finish_model[i] = fin;
        res.proc_number = PROC_W'(i + 1);
        res.none_free = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_assignments.push_back(assign_processor(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_jobs.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
          in_data <= pending_jobs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_assignments.size() == 0) begin
          $display("%0t: unexpected transaction: proc_number %0d none_free %0b",
                   $time, out_data.proc_number, out_data.none_free);
          mismatch_count++;
        end else begin
          due_assignment = expected_assignments.pop_front();
          if (out_data.proc_number !== due_assignment.proc_number) begin
            $display("%0t: proc_number expected %0d actual %0d", $time,
                     due_assignment.proc_number, out_data.proc_number);
            mismatch_count++;
          end
          if (out_data.none_free !== due_assignment.none_free) begin
            $display("%0t: none_free expected %0b actual %0b", $time,
                     due_assignment.none_free, out_data.none_free);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic queue_job(logic [TIME_W-1:0] task_start, logic [TIME_W-1:0] duration);
    in_t job;
    job.task_start = task_start;
    job.duration = duration;
    pending_jobs.push_back(job);
  endtask

  task automatic drain();
    while (pending_jobs.size() != 0 || in_valid || expected_assignments.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active(logic [ACTIVE_W-1:0] value);
    drain();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ACTIVE_PROCS_ADDR;
    pwdata <= ($urandom() & 32'hFFFF_FF80) | {{(DATA_W - ACTIVE_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_active = value;
  endtask

  task automatic run_phase(logic [ACTIVE_W-1:0] active, int count, int span);
    in_t job;
    int pick;
    write_active(active);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        now_time += $urandom_range(0, 3);
        job.task_start = now_time;
        job.duration = $urandom_range(0, span);
      end else if (pick < 92) begin
        job.task_start = $urandom();
        job.duration = $urandom_range(0, 15);
      end else if (pick < 96) begin
        job.task_start = now_time;
        job.duration = $urandom();
      end else begin
        job.task_start = now_time - $urandom_range(0, 40);
        job.duration = $urandom_range(0, span);
      end
      pending_jobs.push_back(job);
    end
  endtask

  initial begin
    for (int i = 0; i < NPROC; i++) begin
      busy_model[i] = 1'b0;
      finish_model[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_job(0, 0);
    queue_job(0, 0);
    queue_job(0, 5);
    queue_job(0, 5);
    queue_job(3, 1);
    queue_job(5, 0);
    queue_job(4, 2);
    queue_job(32'hFFFF_FFFF, 0);
    queue_job(32'hFFFF_FFFF, 0);
    queue_job(32'hAAAA_AAAA, 32'h5555_5555);
    queue_job(32'h5555_5555, 32'hAAAA_AAAA);
    queue_job(32'hFFFF_FFFF, 0);
    queue_job(0, 1);
    write_active(0);
    queue_job(20, 0);
    queue_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_active(1);
    queue_job(10, 5);
    queue_job(11, 1);
    queue_job(15, 0);
    write_active(127);
    queue_job(30, 2);
    queue_job(30, 0);

    run_phase(64, 300, 200);
    run_phase(8, 250, 28);
    run_phase(1, 120, 6);
    run_phase(3, 150, 12);
    in_gap_pct = 0;
    out_stall_pct = 0;
    run_phase(64, 300, 150);
    in_gap_pct = 30;
    out_stall_pct = 30;
    run_phase(127, 200, 400);
    run_phase(100, 150, 100);
    run_phase(0, 30, 10);
    run_phase(ACTIVE_W'($urandom_range(1, 64)), 250, 60);
    run_phase(33, 250, 99);

    write_active(64);
    queue_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_job(32'hFFFF_FFFF, 1);
    queue_job(32'hFFFF_FFFF, 0);
    queue_job(0, 0);
    drain();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
